// File: src/velocity_to_ackermann_steer_unit_defines.svh
// ----------------------------------------------------------------------------
// velocity_to_ackermann_steer_unit_defines
// assertion macros shared by the steering converter rtl
// ----------------------------------------------------------------------------
`ifndef VELOCITY_TO_ACKERMANN_STEER_UNIT_DEFINES_SVH
`define VELOCITY_TO_ACKERMANN_STEER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define VTAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VTAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/vtas_pkg.sv
// ----------------------------------------------------------------------------
// vtas_pkg
// types, widths and the arctangent table of the steering converter
// ----------------------------------------------------------------------------
package vtas_pkg;

	localparam int SPEED_W       = 16;
	localparam int STEER_W       = 12;
	localparam int WB_W          = 12;
	localparam int SPD_LIM_W     = 15;
	localparam int ANG_LIM_W     = 11;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 15;

	localparam int MAG_W         = 15;
	localparam int AYAW_W        = 16;
	localparam int DEN_W         = 25;
	localparam int NUM_W         = 28;
	localparam int SCALE_W       = 10;
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 10'd1000;

	localparam int PRESCALE_BITS   = 24;
	localparam int ANGLE_FRAC_BITS = 30;
	localparam int CORDIC_W        = 56;
	localparam int Z_W             = 33;
	localparam int PROD_W          = 41;
	localparam int MRAD_W          = PROD_W - ANGLE_FRAC_BITS;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (ANGLE_FRAC_BITS - 1));

	localparam int ATAN_TAB_LEN      = 24;
	localparam int ATAN_ITER_DEFAULT = 16;

	// atan(2^-i) in units of 2^-30 rad, truncated
	localparam logic [31:0] ATAN_TAB [ATAN_TAB_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	localparam logic [WB_W-1:0]      WB_RESET       = 12'd260;
	localparam logic [SPD_LIM_W-1:0] MAX_FWD_RESET  = 15'd1000;
	localparam logic [SPD_LIM_W-1:0] MAX_REV_RESET  = 15'd1000;
	localparam logic [ANG_LIM_W-1:0] MAX_STEER_RESET = 11'd600;
	localparam logic [SPD_LIM_W-1:0] DEADBAND_RESET = 15'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEELBASE = 3'd0,
		REG_MAX_FWD   = 3'd1,
		REG_MAX_REV   = 3'd2,
		REG_MAX_STEER = 3'd3,
		REG_DEADBAND  = 3'd4
	} cfg_reg_t;

	typedef logic signed [CORDIC_W-1:0] cordic_t;
	typedef logic signed [Z_W-1:0]      angle_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] linear_speed;
		logic signed [SPEED_W-1:0] yaw_rate;
	} in_word_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] drive_speed;
		logic signed [STEER_W-1:0] steer_angle;
	} out_word_t;

	// rides alongside the angle through the rotation stages
	typedef struct packed {
		logic signed [SPEED_W-1:0] speed;
		logic                      neg;
		logic                      en;
	} steer_side_t;

endpackage

// File: src/vtas_cordic.sv
// ----------------------------------------------------------------------------
// vtas_cordic
// pipelined cordic vectoring, one rotation per register stage
// ----------------------------------------------------------------------------
module vtas_cordic #(
	parameter int ITERATIONS = vtas_pkg::ATAN_ITER_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vtas_pkg::cordic_t    x_in,
	input  vtas_pkg::cordic_t    y_in,
	input  vtas_pkg::steer_side_t side_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output vtas_pkg::angle_t     z_out,
	output vtas_pkg::steer_side_t side_out
);
	import vtas_pkg::*;

	localparam int N = (ITERATIONS < ATAN_TAB_LEN) ? ITERATIONS : ATAN_TAB_LEN;

	cordic_t     x_s    [N];
	cordic_t     y_s    [N];
	angle_t      z_s    [N];
	steer_side_t side_s [N];
	logic        vld_s  [N];
	logic        ld     [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		cordic_t     xi, yi, xsh, ysh;
		angle_t      zi, tk;
		steer_side_t si;
		logic        vi, nrdy, pos;

		if (k == 0) begin : g_first
			assign xi = x_in;
			assign yi = y_in;
			assign zi = '0;
			assign si = side_in;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
			assign si = side_s[k-1];
			assign vi = vld_s[k-1];
		end

		if (k == N - 1) begin : g_last
			assign nrdy = out_ready;
		end else begin : g_mid
			assign nrdy = ld[k+1];
		end

		assign ld[k] = !vld_s[k] || nrdy;

		// arithmetic shift rounds toward minus infinity
		assign xsh = xi >>> k;
		assign ysh = yi >>> k;
		assign tk  = angle_t'({1'b0, ATAN_TAB[k]});
		assign pos = !yi[CORDIC_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ld[k]) begin
				vld_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k] && vi) begin
				side_s[k] <= si;
				if (pos) begin
					x_s[k] <= xi + ysh;
					y_s[k] <= yi - xsh;
					z_s[k] <= zi + tk;
				end else begin
					x_s[k] <= xi - ysh;
					y_s[k] <= yi + xsh;
					z_s[k] <= zi - tk;
				end
			end
		end
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_s[N-1];
	assign z_out     = z_s[N-1];
	assign side_out  = side_s[N-1];

endmodule

// File: src/velocity_to_ackermann_steer_unit.sv
// A new speed/yaw-rate word can be taken every clock cycle while the output is not
// stalled, and each word gives one result word after stages 1 and 2, the cordic
// arctangent, which spends one register stage per rotation, and stages 3 and 4.
// Speed is clamped between the negated reverse limit and the forward limit;
// above the turning dead band the steering angle is atan(wheelbase * yaw / (1000 * speed)),
// rounded to mrad and limited to +/-max_steer_angle, else zero. Write the configuration
// registers only while no word is in flight.
// ----------------------------------------------------------------------------
// velocity_to_ackermann_steer_unit
// speed and yaw rate to clamped drive speed and bicycle-model steering angle
// ----------------------------------------------------------------------------
`include "velocity_to_ackermann_steer_unit_defines.svh"

module velocity_to_ackermann_steer_unit #(
	parameter int ATAN_ITERATIONS = vtas_pkg::ATAN_ITER_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [vtas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vtas_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  vtas_pkg::in_word_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output vtas_pkg::out_word_t               out_data
);
	import vtas_pkg::*;

	logic [WB_W-1:0]      wheelbase_q;
	logic [SPD_LIM_W-1:0] max_fwd_q;
	logic [SPD_LIM_W-1:0] max_rev_q;
	logic [ANG_LIM_W-1:0] max_steer_q;
	logic [SPD_LIM_W-1:0] deadband_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= WB_RESET;
			max_fwd_q   <= MAX_FWD_RESET;
			max_rev_q   <= MAX_REV_RESET;
			max_steer_q <= MAX_STEER_RESET;
			deadband_q  <= DEADBAND_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_WHEELBASE: wheelbase_q <= cfg_data[WB_W-1:0];
				REG_MAX_FWD:   max_fwd_q   <= cfg_data[SPD_LIM_W-1:0];
				REG_MAX_REV:   max_rev_q   <= cfg_data[SPD_LIM_W-1:0];
				REG_MAX_STEER: max_steer_q <= cfg_data[ANG_LIM_W-1:0];
				REG_DEADBAND:  deadband_q  <= cfg_data[SPD_LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake chain: a stage loads when empty or when its word moves on
	logic v_s1, v_s2, v_s3, v_s4;
	logic ld_s1, ld_s2, ld_s3, ld_s4;
	logic cor_in_ready, cor_out_valid;

	assign ld_s4    = !v_s4 || out_ready;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || cor_in_ready;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	// stage 1: speed clamp and magnitudes
	logic signed [SPEED_W:0] v_ext, y_ext, lo, hi, s_clamp, s_abs, y_abs;
	logic                    neg_c;

	always_comb begin
		v_ext   = {in_data.linear_speed[SPEED_W-1], in_data.linear_speed};
		y_ext   = {in_data.yaw_rate[SPEED_W-1], in_data.yaw_rate};
		lo      = -$signed({2'b00, max_rev_q});
		hi      = $signed({2'b00, max_fwd_q});
		s_clamp = v_ext;
		if (s_clamp < lo) begin
			s_clamp = lo;
		end
		if (s_clamp > hi) begin
			s_clamp = hi;
		end
		s_abs = s_clamp[SPEED_W] ? -s_clamp : s_clamp;
		y_abs = y_ext[SPEED_W] ? -y_ext : y_ext;
		neg_c = y_ext[SPEED_W] ^ s_clamp[SPEED_W];
	end

	logic signed [SPEED_W-1:0] speed_s1;
	logic [MAG_W-1:0]          mag_s1;
	logic [AYAW_W-1:0]         ayaw_s1;
	logic                      neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			speed_s1 <= s_clamp[SPEED_W-1:0];
			mag_s1   <= s_abs[MAG_W-1:0];
			ayaw_s1  <= y_abs[AYAW_W-1:0];
			neg_s1   <= neg_c;
		end
	end

	// stage 2: cordic vector from 1000*|speed| and wheelbase*|yaw|
	logic [DEN_W-1:0] den_c, den_s2;
	logic [NUM_W-1:0] num_c, num_s2;
	steer_side_t      side_c, side_s2;

	assign den_c = DEN_W'(mag_s1) * DEN_W'(SPEED_SCALE);
	assign num_c = NUM_W'(wheelbase_q) * NUM_W'(ayaw_s1);

	always_comb begin
		side_c.speed = speed_s1;
		side_c.neg   = neg_s1;
		side_c.en    = (mag_s1 > deadband_q) && (wheelbase_q != '0) && (ayaw_s1 != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && v_s1) begin
			den_s2  <= den_c;
			num_s2  <= num_c;
			side_s2 <= side_c;
		end
	end

	cordic_t     x0, y0;
	angle_t      z_cor;
	steer_side_t side_cor;

	assign x0 = cordic_t'({den_s2, {PRESCALE_BITS{1'b0}}});
	assign y0 = cordic_t'({num_s2, {PRESCALE_BITS{1'b0}}});

	vtas_cordic #(
		.ITERATIONS (ATAN_ITERATIONS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (cor_in_ready),
		.x_in      (x0),
		.y_in      (y0),
		.side_in   (side_s2),
		.out_valid (cor_out_valid),
		.out_ready (ld_s3),
		.z_out     (z_cor),
		.side_out  (side_cor)
	);

	// stage 3: angle to mrad, rounding half up
	logic [Z_W-2:0]    z_pos;
	logic [PROD_W-1:0] prod_c;
	logic [MRAD_W-1:0] m_s3;
	steer_side_t       side_s3;

	assign z_pos  = z_cor[Z_W-1] ? '0 : z_cor[Z_W-2:0];
	assign prod_c = PROD_W'(z_pos) * PROD_W'(SPEED_SCALE) + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ld_s3) begin
			v_s3 <= cor_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && cor_out_valid) begin
			m_s3    <= prod_c[PROD_W-1:ANGLE_FRAC_BITS];
			side_s3 <= side_cor;
		end
	end

	// stage 4: steering limit, sign and dead band, output register
	logic [MRAD_W-1:0]         m_lim;
	logic signed [STEER_W-1:0] steer_c;
	out_word_t                 out_s4;

	always_comb begin
		m_lim = (m_s3 > MRAD_W'(max_steer_q)) ? MRAD_W'(max_steer_q) : m_s3;
		if (!side_s3.en) begin
			steer_c = '0;
		end else if (side_s3.neg) begin
			steer_c = -$signed(STEER_W'(m_lim));
		end else begin
			steer_c = $signed(STEER_W'(m_lim));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ld_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4 && v_s3) begin
			out_s4.drive_speed <= side_s3.speed;
			out_s4.steer_angle <= steer_c;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = out_s4;

	`VTAS_ASSERT_NEXT(a_steer_limit, ld_s4 && v_s3, (out_data.steer_angle <= $signed(STEER_W'($past(max_steer_q)))) && (out_data.steer_angle >= -$signed(STEER_W'($past(max_steer_q)))), "steering angle beyond limit")
	`VTAS_ASSERT_NEXT(a_deadband_zero, ld_s4 && v_s3 && !side_s3.en, out_data.steer_angle == '0, "steering not zero in dead band")
	`VTAS_ASSERT_NEXT(a_steer_sign, ld_s4 && v_s3 && side_s3.en && !side_s3.neg, !out_data.steer_angle[STEER_W-1], "steering sign flipped")
	`VTAS_ASSERT_NOW(a_stall_held, !in_ready, v_s1 && v_s2, "input stalled with a free front stage")

endmodule

// File: bench/velocity_to_ackermann_steer_unit_tb.sv
// ----------------------------------------------------------------------------
// velocity_to_ackermann_steer_unit_tb
// self-checking bench for the speed/yaw-rate to steering converter: a bit-exact
// cordic predictor queues the expected word for each accepted input and a
// checker compares every result word against it, under random idling on both
// sides, a long output stall and several register settings
// ----------------------------------------------------------------------------
module velocity_to_ackermann_steer_unit_tb;
	import vtas_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam int DUT_LATENCY  = 4 + CORDIC_STEPS;
	localparam int STALL_LIMIT  = 3000;
	localparam int PRE_SHIFT    = 24;
	localparam int ANG_FRAC     = 30;
	localparam int STEP_TAB_LEN = 24;

	// atan(2^-i), 2^-30 rad units, truncated
	localparam longint ATAN_STEP_TAB [STEP_TAB_LEN] = '{
		'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
		'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
		'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
		'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;

	// shadow copy of the block's registers
	logic [WB_W-1:0]      wheelbase = WB_RESET;
	logic [SPD_LIM_W-1:0] max_fwd   = MAX_FWD_RESET;
	logic [SPD_LIM_W-1:0] max_rev   = MAX_REV_RESET;
	logic [ANG_LIM_W-1:0] max_steer = MAX_STEER_RESET;
	logic [SPD_LIM_W-1:0] deadband  = DEADBAND_RESET;

	out_word_t steer_expect[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        tx_gap_pct = 0;
	int        rx_stall_pct = 0;
	int        hold_request = 0;

	velocity_to_ackermann_steer_unit #(
		.ATAN_ITERATIONS(CORDIC_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic out_word_t predict_steer(in_word_t w);
		int        spd;
		int        yaw;
		int        mag;
		int        ang;
		longint    num;
		longint    x;
		longint    y;
		longint    z;
		longint    xs;
		longint    ys;
		out_word_t r;
		spd = w.linear_speed;
		yaw = w.yaw_rate;
		if (spd < -int'(max_rev))
			spd = -int'(max_rev);
		if (spd > int'(max_fwd))
			spd = int'(max_fwd);
		mag = (spd < 0) ? -spd : spd;
		ang = 0;
		if (mag > int'(deadband)) begin
			num = longint'(wheelbase) * longint'((yaw < 0) ? -yaw : yaw);
			if (num != 0) begin
				x = (longint'(mag) * 1000) <<< PRE_SHIFT;
				y = num <<< PRE_SHIFT;
				z = 0;
				for (int i = 0; i < CORDIC_STEPS && i < STEP_TAB_LEN; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (y >= 0) begin
						x = x + ys;
						y = y - xs;
						z = z + ATAN_STEP_TAB[i];
					end else begin
						x = x - ys;
						y = y + xs;
						z = z - ATAN_STEP_TAB[i];
					end
				end
				if (z < 0)
					z = 0;
				ang = int'((z * 1000 + (64'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC);
				if (ang > int'(max_steer))
					ang = int'(max_steer);
				if ((yaw < 0) != (spd < 0))
					ang = -ang;
			end
		end
		r.drive_speed = SPEED_W'(spd);
		r.steer_angle = STEER_W'(ang);
		return r;
	endfunction

	// mostly random, sometimes an end of the range
	function automatic int pick_reg(int lo, int hi);
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int       mag;
		int       lim;
		case ($urandom_range(3))
			0: w.linear_speed = SPEED_W'($urandom);
			1: begin
				mag = $urandom_range(0, int'(deadband) + 40);
				w.linear_speed = SPEED_W'($urandom_range(1) ? mag : -mag);
			end
			2: begin
				lim = $urandom_range(1) ? int'(max_fwd) : -int'(max_rev);
				mag = $urandom_range(0, 10);
				w.linear_speed = SPEED_W'(lim + mag - 5);
			end
			default: begin
				mag = $urandom_range(0, 4000);
				w.linear_speed = SPEED_W'(mag - 2000);
			end
		endcase
		case ($urandom_range(7))
			0, 1: w.yaw_rate = SPEED_W'($urandom);
			2: w.yaw_rate = '0;
			default: begin
				mag = $urandom_range(0, 6000);
				w.yaw_rate = SPEED_W'(mag - 3000);
			end
		endcase
		return w;
	endfunction

	// returns at the edge where the word was taken
	task automatic send_word(in_word_t w);
		int gap;
		gap = 0;
		if (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct)
			gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		steer_expect.push_back(predict_steer(w));
	endtask

	task automatic send_pair(int spd, int yaw);
		in_word_t w;
		w.linear_speed = SPEED_W'(spd);
		w.yaw_rate     = SPEED_W'(yaw);
		send_word(w);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (steer_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
		wait_drained();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(data);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_WHEELBASE: wheelbase = data[WB_W-1:0];
			REG_MAX_FWD:   max_fwd   = data[SPD_LIM_W-1:0];
			REG_MAX_REV:   max_rev   = data[SPD_LIM_W-1:0];
			REG_MAX_STEER: max_steer = data[ANG_LIM_W-1:0];
			REG_DEADBAND:  deadband  = data[SPD_LIM_W-1:0];
			default: ;
		endcase
	endtask

	// reset settings: dead band, clamps, signs, zero yaw
	task automatic test_reset_settings();
		tx_gap_pct   = 30;
		rx_stall_pct = 20;
		send_pair(0, 1000);
		send_pair(1, 500);
		send_pair(-1, 500);
		send_pair(2, 500);
		send_pair(-2, 500);
		send_pair(32767, 100);
		send_pair(-32768, -100);
		send_pair(500, 1000);
		send_pair(500, -1000);
		send_pair(-500, 1000);
		send_pair(-500, -1000);
		send_pair(1000, 32767);
		send_pair(1000, -32768);
		send_pair(1000, 0);
		send_pair(300, 1);
	endtask

	task automatic test_register_limits();
		write_reg(REG_WHEELBASE, 4095);
		write_reg(REG_MAX_FWD, 32767);
		write_reg(REG_MAX_REV, 32767);
		write_reg(REG_MAX_STEER, 2047);
		write_reg(REG_DEADBAND, 0);
		send_pair(32767, 32767);
		send_pair(-32768, -32768);
		send_pair(1, 32767);
		send_pair(-1, 1);
		send_pair(0, 5);
		write_reg(REG_MAX_STEER, 1571);
		send_pair(1, -32768);
		write_reg(REG_MAX_STEER, 0);
		send_pair(100, 100);
		write_reg(REG_DEADBAND, 32767);
		send_pair(32767, 1000);
		write_reg(REG_DEADBAND, 0);
		write_reg(REG_MAX_FWD, 0);
		write_reg(REG_MAX_REV, 0);
		send_pair(500, 500);
		send_pair(-500, 500);
		// upper bits dropped: wheelbase becomes zero, then all ones
		write_reg(REG_MAX_FWD, 1000);
		write_reg(REG_MAX_REV, 1000);
		write_reg(REG_MAX_STEER, 15'h7FFF);
		write_reg(REG_WHEELBASE, 15'h1000);
		send_pair(500, 500);
		write_reg(REG_WHEELBASE, 15'h7FFF);
		for (int i = REG_DEADBAND + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), $urandom);
		send_pair(-700, 900);
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 7; phase++) begin
			if ($urandom_range(3) == 0)
				write_reg(REG_WHEELBASE, $urandom);
			else
				write_reg(REG_WHEELBASE, pick_reg(1, 4095));
			write_reg(REG_MAX_FWD, pick_reg(0, 32767));
			write_reg(REG_MAX_REV, pick_reg(0, 32767));
			write_reg(REG_MAX_STEER, pick_reg(0, 2047));
			write_reg(REG_DEADBAND, ($urandom_range(7) == 0) ? 32767 : $urandom_range(0, 200));
			if ($urandom_range(2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_DEADBAND + 1, (1 << CFG_IDX_W) - 1)),
					$urandom);
			// first phase runs flat out on both sides
			tx_gap_pct   = (phase == 0) ? 0 : $urandom_range(5, 50);
			rx_stall_pct = (phase == 0) ? 0 : $urandom_range(5, 50);
			for (int n = 0; n < 130; n++)
				send_word(random_word());
		end
	endtask

	// receiver holds off long enough for the pipeline to fill and stall the input
	task automatic test_output_stall();
		write_reg(REG_WHEELBASE, 260);
		write_reg(REG_MAX_FWD, 3000);
		write_reg(REG_MAX_REV, 3000);
		write_reg(REG_MAX_STEER, 1200);
		write_reg(REG_DEADBAND, 10);
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		hold_request = 300;
		for (int n = 0; n < 80; n++)
			send_word(random_word());
		rx_stall_pct = 20;
	endtask

	initial begin : drain_ctl
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold == 0 && hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end else if (hold == 0 && rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
				hold = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (steer_expect.size() == 0) begin
				$error("result word with none expected: drive_speed %0d steer_angle %0d",
					out_data.drive_speed, out_data.steer_angle);
				mismatches++;
			end else begin
				want = steer_expect.pop_front();
				if (out_data.drive_speed !== want.drive_speed) begin
					$error("drive_speed: expected %0d, got %0d", want.drive_speed,
						out_data.drive_speed);
					mismatches++;
				end
				if (out_data.steer_angle !== want.steer_angle) begin
					$error("steer_angle: expected %0d, got %0d", want.steer_angle,
						out_data.steer_angle);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** velocity_to_ackermann_steer_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_settings();
		test_register_limits();
		test_random_settings();
		test_output_stall();
		wait_drained();
		repeat (DUT_LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && steer_expect.size() == 0)
			$display("** velocity_to_ackermann_steer_unit: PASSED **");
		else
			$display("** velocity_to_ackermann_steer_unit: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/vtas_pkg.sv
src/vtas_cordic.sv
src/velocity_to_ackermann_steer_unit.sv
bench/velocity_to_ackermann_steer_unit_tb.sv
